### rtl/hkra_pkg.sv
// ----------------------------------------------------------------------------
// hkra_pkg
// Types, constants and the usage-code to ASCII mapping for the boot keyboard
// report to ASCII unit.
// ----------------------------------------------------------------------------
package hkra_pkg;

    // Number of key slots a boot report can carry
    localparam int SLOT_DEPTH = 6;

    // Modifier masks (left and right keys)
    localparam logic [7:0] SHIFT_MASK = 8'h22;
    localparam logic [7:0] CTRL_MASK  = 8'h11;

    // Usage code ranges
    localparam logic [7:0] LETTER_FIRST = 8'h04;
    localparam logic [7:0] LETTER_LAST  = 8'h1D;
    localparam logic [7:0] DIGIT_FIRST  = 8'h1E;
    localparam logic [7:0] DIGIT_LAST   = 8'h27;
    localparam logic [7:0] CTLKEY_FIRST = 8'h28;
    localparam logic [7:0] CTLKEY_LAST  = 8'h2C;
    localparam logic [7:0] SYMBOL_FIRST = 8'h2D;
    localparam logic [7:0] SYMBOL_LAST  = 8'h38;
    localparam logic [7:0] KEYPAD_FIRST = 8'h54;
    localparam logic [7:0] KEYPAD_LAST  = 8'h63;

    // Escape character
    localparam logic [6:0] ASCII_ESC = 7'h1B;

    // Input request: one boot keyboard report
    typedef struct packed {
        logic [7:0] modifier_bits;
        logic [7:0] key_code_0;
        logic [7:0] key_code_1;
        logic [7:0] key_code_2;
        logic [7:0] key_code_3;
        logic [7:0] key_code_4;
        logic [7:0] key_code_5;
        logic [3:0] report_length;
    } hkra_report_t;

    // Output request: one character
    typedef struct packed {
        logic [6:0] ascii_char;
        logic       last_of_report;
    } hkra_result_t;

    // What one lane hands to the merge stage
    typedef struct packed {
        logic       hit;        // newly pressed and mapped
        logic [6:0] ascii;      // mapped character
        logic [7:0] stored_key; // key code to keep for the next report
    } hkra_lane_res_t;

    // Key code of one slot of a report
    function automatic logic [7:0] slot_key(hkra_report_t rpt, int idx);
        logic [7:0] k;
        case (idx)
            0:       k = rpt.key_code_0;
            1:       k = rpt.key_code_1;
            2:       k = rpt.key_code_2;
            3:       k = rpt.key_code_3;
            4:       k = rpt.key_code_4;
            5:       k = rpt.key_code_5;
            default: k = 8'h00;
        endcase
        return k;
    endfunction

    // Number row, plain and shifted
    function automatic logic [6:0] digit_char(logic [3:0] off, logic shift);
        logic [6:0] c;
        case (off)
            4'd0:    c = shift ? 7'h21 : 7'h31;
            4'd1:    c = shift ? 7'h40 : 7'h32;
            4'd2:    c = shift ? 7'h23 : 7'h33;
            4'd3:    c = shift ? 7'h24 : 7'h34;
            4'd4:    c = shift ? 7'h25 : 7'h35;
            4'd5:    c = shift ? 7'h5E : 7'h36;
            4'd6:    c = shift ? 7'h26 : 7'h37;
            4'd7:    c = shift ? 7'h2A : 7'h38;
            4'd8:    c = shift ? 7'h28 : 7'h39;
            4'd9:    c = shift ? 7'h29 : 7'h30;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // Enter, escape, backspace, tab, space
    function automatic logic [6:0] ctlkey_char(logic [2:0] off);
        logic [6:0] c;
        case (off)
            3'd0:    c = 7'h0A;
            3'd1:    c = ASCII_ESC;
            3'd2:    c = 7'h08;
            3'd3:    c = 7'h09;
            3'd4:    c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // US symbol keys; non-US hash key left unmapped
    function automatic logic [6:0] symbol_char(logic [3:0] off, logic shift);
        logic [6:0] c;
        case (off)
            4'd0:    c = shift ? 7'h5F : 7'h2D;
            4'd1:    c = shift ? 7'h2B : 7'h3D;
            4'd2:    c = shift ? 7'h7B : 7'h5B;
            4'd3:    c = shift ? 7'h7D : 7'h5D;
            4'd4:    c = shift ? 7'h7C : 7'h5C;
            4'd6:    c = shift ? 7'h3A : 7'h3B;
            4'd7:    c = shift ? 7'h22 : 7'h27;
            4'd8:    c = shift ? 7'h7E : 7'h60;
            4'd9:    c = shift ? 7'h3C : 7'h2C;
            4'd10:   c = shift ? 7'h3E : 7'h2E;
            4'd11:   c = shift ? 7'h3F : 7'h2F;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // Keypad, shift has no effect
    function automatic logic [6:0] keypad_char(logic [3:0] off);
        logic [6:0] c;
        case (off)
            4'd0:    c = 7'h2F;
            4'd1:    c = 7'h2A;
            4'd2:    c = 7'h2D;
            4'd3:    c = 7'h2B;
            4'd4:    c = 7'h0A;
            4'd5:    c = 7'h31;
            4'd6:    c = 7'h32;
            4'd7:    c = 7'h33;
            4'd8:    c = 7'h34;
            4'd9:    c = 7'h35;
            4'd10:   c = 7'h36;
            4'd11:   c = 7'h37;
            4'd12:   c = 7'h38;
            4'd13:   c = 7'h39;
            4'd14:   c = 7'h30;
            default: c = 7'h2E;
        endcase
        return c;
    endfunction

    // Usage code to US ASCII; zero means unmapped
    function automatic logic [6:0] map_key(logic [7:0] k, logic shift, logic ctrl);
        logic [7:0] off;
        logic [6:0] c;
        off = 8'h00;
        c   = 7'h00;
        if (k >= LETTER_FIRST && k <= LETTER_LAST) begin
            off = k - LETTER_FIRST;
            if (shift)
                c = 7'h41 + off[6:0];
            else if (ctrl)
                c = 7'h01 + off[6:0];
            else
                c = 7'h61 + off[6:0];
        end else if (k >= DIGIT_FIRST && k <= DIGIT_LAST) begin
            off = k - DIGIT_FIRST;
            c   = digit_char(off[3:0], shift);
        end else if (k >= CTLKEY_FIRST && k <= CTLKEY_LAST) begin
            off = k - CTLKEY_FIRST;
            c   = ctlkey_char(off[2:0]);
        end else if (k >= SYMBOL_FIRST && k <= SYMBOL_LAST) begin
            off = k - SYMBOL_FIRST;
            c   = symbol_char(off[3:0], shift);
        end else if (k >= KEYPAD_FIRST && k <= KEYPAD_LAST) begin
            off = k - KEYPAD_FIRST;
            c   = keypad_char(off[3:0]);
        end
        return c;
    endfunction

endpackage

### rtl/hkra_lane.sv
// ----------------------------------------------------------------------------
// hkra_lane
// One key slot: checks the slot against the length, looks for the code in
// the previous report and maps a new press to ASCII.
// ----------------------------------------------------------------------------
module hkra_lane
    import hkra_pkg::*;
#(
    parameter int SLOT_INDEX = 0,
    parameter int KEY_SLOTS  = 6
) (
    input  logic [7:0]                 key_code,
    input  logic [3:0]                 report_length,
    input  logic                       shift,
    input  logic                       ctrl,
    input  logic [KEY_SLOTS-1:0][7:0]  prev_keys,
    output hkra_lane_res_t             res
);

    localparam logic [3:0] SLOT_BYTE = 4'(SLOT_INDEX + 2);

    logic       used;
    logic [7:0] key;
    logic       seen;
    logic [6:0] ascii;

    // Slot counts only when its report byte was received
    assign used = report_length > SLOT_BYTE;
    assign key  = used ? key_code : 8'h00;

    // Match against every stored slot of the previous report
    always_comb
    begin
        seen = 1'b0;
        for (int j = 0; j < KEY_SLOTS; j++)
        begin
            if (prev_keys[j] == key)
                seen = 1'b1;
        end
    end

    assign ascii = map_key(key, shift, ctrl);

    assign res.hit        = (key != 8'h00) && !seen && (ascii != 7'h00);
    assign res.ascii      = ascii;
    assign res.stored_key = key;

endmodule

### rtl/hkra_merge.sv
// ----------------------------------------------------------------------------
// hkra_merge
// Holds the characters one report produced and sends them out in slot
// order, one per cycle while ascii_ready does not stall them, through an output register.
// ----------------------------------------------------------------------------
module hkra_merge
    import hkra_pkg::*;
#(
    parameter int KEY_SLOTS = 6
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  hkra_lane_res_t [KEY_SLOTS-1:0]     lane_res,
    output logic                               can_load,
    output logic                               ascii_valid,
    input  logic                               ascii_ready,
    output hkra_result_t                       ascii_result
);

    logic [KEY_SLOTS-1:0]      pend_reg;
    logic [KEY_SLOTS-1:0]      pend_next;
    logic [KEY_SLOTS-1:0][6:0] chars_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    hkra_result_t              out_reg;
    hkra_result_t              out_next;

    logic                      pop;
    logic [KEY_SLOTS-1:0]      lowest;
    logic [KEY_SLOTS-1:0]      remaining;
    logic [6:0]                pick;
    logic [KEY_SLOTS-1:0]      hits;

    // Lowest pending slot goes next
    assign lowest    = pend_reg & (~pend_reg + KEY_SLOTS'(1));
    assign remaining = pend_reg & ~lowest;
    assign pop       = (pend_reg != '0) && (!out_valid_reg || ascii_ready);
    assign can_load  = (pend_reg == '0) || (pop && (remaining == '0));

    always_comb
    begin
        pick = 7'h00;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            if (lowest[i])
                pick = chars_reg[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < KEY_SLOTS; i++)
            hits[i] = lane_res[i].hit;
    end

    // Pending mask and output register next values
    always_comb
    begin
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (pop)
        begin
            pend_next                = remaining;
            out_valid_next           = 1'b1;
            out_next.ascii_char      = pick;
            out_next.last_of_report  = (remaining == '0);
        end else if (ascii_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
            pend_next = hits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (load)
        begin
            for (int i = 0; i < KEY_SLOTS; i++)
                chars_reg[i] <= lane_res[i].ascii;
        end
    end

    assign ascii_valid  = out_valid_reg;
    assign ascii_result = out_reg;

endmodule

### rtl/hid_keyboard_report_to_ascii_unit.sv
// ----------------------------------------------------------------------------
// hid_keyboard_report_to_ascii_unit
// Boot keyboard report to US ASCII: one lane per key slot finds new presses,
// the merge stage sends the characters out in slot order.
// ----------------------------------------------------------------------------
// The first character of a report passes the pending mask, then the output register.
// Throughput: one character per cycle while ascii_ready does not stall the output;
//   a report's characters wait in the merge buffer ahead of the single output register.
// A report is taken while the previous one's last character is going out.
// Reset (rst_n low, asynchronous) clears the stored previous report and
//   empties the buffer and output register.
module hid_keyboard_report_to_ascii_unit
    import hkra_pkg::*;
#(
    parameter int KEY_SLOTS = 6
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         key_valid,
    output logic         key_ready,
    input  hkra_report_t key_report,
    output logic         ascii_valid,
    input  logic         ascii_ready,
    output hkra_result_t ascii_result
);

    logic [KEY_SLOTS-1:0][7:0]     prev_keys_reg;
    logic [KEY_SLOTS-1:0][7:0]     prev_keys_next;
    hkra_lane_res_t [KEY_SLOTS-1:0] lane_res;
    logic                          shift;
    logic                          ctrl;
    logic                          accept;
    logic                          can_load;

    assign shift     = (key_report.modifier_bits & SHIFT_MASK) != 8'h00;
    assign ctrl      = (key_report.modifier_bits & CTRL_MASK) != 8'h00;
    assign key_ready = can_load;
    assign accept    = key_valid && key_ready;

    // One lane per key slot
    for (genvar g = 0; g < KEY_SLOTS; g++)
    begin : g_lane
        hkra_lane #(
            .SLOT_INDEX (g),
            .KEY_SLOTS  (KEY_SLOTS)
        ) u_lane (
            .key_code      (slot_key(key_report, g)),
            .report_length (key_report.report_length),
            .shift         (shift),
            .ctrl          (ctrl),
            .prev_keys     (prev_keys_reg),
            .res           (lane_res[g])
        );
    end

    // Store the report; an empty report leaves the state alone
    always_comb
    begin
        prev_keys_next = prev_keys_reg;
        if (accept && (key_report.report_length != 4'd0))
        begin
            for (int i = 0; i < KEY_SLOTS; i++)
                prev_keys_next[i] = lane_res[i].stored_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_keys_reg <= '0;
        else
            prev_keys_reg <= prev_keys_next;
    end

    hkra_merge #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .lane_res     (lane_res),
        .can_load     (can_load),
        .ascii_valid  (ascii_valid),
        .ascii_ready  (ascii_ready),
        .ascii_result (ascii_result)
    );

endmodule
